>>> design/pwa_pkg.sv
`timescale 1ns / 1ps

package pwa_pkg;

    localparam int MAX_VERTICES = 1024;

    localparam int COORD_W = 16;
    localparam int VERT_W  = 2 * COORD_W;
    localparam int WIND_W  = 12;
    localparam int AREA_W  = 43;
    localparam int VCNT_W  = 11;

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    localparam int OP_W   = COORD_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int DIFF_W = PROD_W + 1;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int WACC_W = max_int(CNT_W + 1, WIND_W + 1);
    localparam int AACC_W = max_int(DIFF_W + CNT_W, AREA_W + 1);

    localparam logic signed [WACC_W-1:0] WIND_HI =
        {{(WACC_W - WIND_W + 1){1'b0}}, {(WIND_W - 1){1'b1}}};
    localparam logic signed [WACC_W-1:0] WIND_LO = ~WIND_HI;
    localparam logic signed [AACC_W-1:0] AREA_HI =
        {{(AACC_W - AREA_W + 1){1'b0}}, {(AREA_W - 1){1'b1}}};
    localparam logic signed [AACC_W-1:0] AREA_LO = ~AREA_HI;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_POINT  = 2'd2,
        KIND_AREA   = 2'd3
    } pwa_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_CLOSE,
        ST_DRAIN,
        ST_FINISH
    } pwa_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic area_mode;
    } pwa_edge_ctl_t;

endpackage

>>> design/polygon_winding_and_area_unit.sv
`timescale 1ns / 1ps

// Clear and append commands finish without a walk: done pulses in the cycle after
// the transfer and busy stays low. A point or area query over n stored vertices
// keeps busy high through the WALK, CLOSE, DRAIN and FINISH states, and done
// pulses in the cycle in which busy falls. The single read port of the vertex memory
// streams one vertex per cycle into the shared two-stage edge multiplier/accumulator.
// A query on an empty store is answered as clear and append are. done is a one-cycle
// strobe that the receiver cannot stall; vertex_count and overflowed show the state
// after the item while done is high.
module polygon_winding_and_area_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic signed [pwa_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [pwa_pkg::COORD_W-1:0]  y_coord,
    output logic                                done,
    output logic                                inside_res,
    output logic signed [pwa_pkg::WIND_W-1:0]   winding,
    output logic signed [pwa_pkg::AREA_W-1:0]   double_area,
    output logic                                clockwise,
    output logic [pwa_pkg::VCNT_W-1:0]          vertex_count,
    output logic                                overflowed
);

    pwa_pkg::pwa_state_t state_reg, state_next;

    logic [pwa_pkg::CNT_W-1:0]   count_reg;
    logic                        ovf_reg;
    logic [pwa_pkg::VERT_W-1:0]  last_reg;
    logic [pwa_pkg::ADDR_W-1:0]  idx_reg;
    logic [pwa_pkg::VERT_W-1:0]  first_reg, prev_reg;
    logic signed [pwa_pkg::COORD_W-1:0] px_reg, py_reg;
    logic                        area_mode_reg;

    logic                        done_reg, inside_reg, cw_reg;
    logic signed [pwa_pkg::WIND_W-1:0] wind_res_reg;
    logic signed [pwa_pkg::AREA_W-1:0] area_res_reg;

    logic                        accept, last_vertex, is_dup, is_full, do_write;
    logic [pwa_pkg::VERT_W-1:0]  packed_in, rdata, edge_b;
    logic [pwa_pkg::ADDR_W-1:0]  raddr;
    pwa_pkg::pwa_kind_t          kind_in;
    pwa_pkg::pwa_edge_ctl_t      ectl;

    logic signed [pwa_pkg::WACC_W-1:0] wind_acc, wind_sat;
    logic signed [pwa_pkg::AACC_W-1:0] area_acc, area_sat;

    assign kind_in     = pwa_pkg::pwa_kind_t'(kind);
    assign accept      = start && (state_reg == pwa_pkg::ST_IDLE);
    assign packed_in   = {y_coord, x_coord};
    assign is_dup      = (count_reg != '0) && (last_reg == packed_in);
    assign is_full     = count_reg >= pwa_pkg::CNT_W'(pwa_pkg::MAX_VERTICES);
    assign do_write    = accept && (kind_in == pwa_pkg::KIND_APPEND) && !is_dup && !is_full;
    assign last_vertex = (pwa_pkg::CNT_W'(idx_reg) + pwa_pkg::CNT_W'(1)) == count_reg;
    assign raddr       = (state_reg == pwa_pkg::ST_WALK) ? idx_reg + pwa_pkg::ADDR_W'(1) : '0;
    assign edge_b      = (state_reg == pwa_pkg::ST_CLOSE) ? first_reg : rdata;

    pwa_vertex_store u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (count_reg[pwa_pkg::ADDR_W-1:0]),
        .wdata (packed_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    pwa_edge_unit u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ectl),
        .ax       (prev_reg[pwa_pkg::COORD_W-1:0]),
        .ay       (prev_reg[pwa_pkg::VERT_W-1:pwa_pkg::COORD_W]),
        .bx       (edge_b[pwa_pkg::COORD_W-1:0]),
        .by       (edge_b[pwa_pkg::VERT_W-1:pwa_pkg::COORD_W]),
        .px       (px_reg),
        .py       (py_reg),
        .wind_acc (wind_acc),
        .area_acc (area_acc)
    );

    always_comb
    begin
        state_next     = state_reg;
        ectl.clear     = 1'b0;
        ectl.valid     = 1'b0;
        ectl.area_mode = area_mode_reg;
        case (state_reg)
            pwa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ectl.clear = 1'b1;
                    if ((kind_in == pwa_pkg::KIND_POINT || kind_in == pwa_pkg::KIND_AREA)
                        && count_reg != '0)
                    begin
                        state_next = pwa_pkg::ST_WALK;
                    end
                end
            end
            pwa_pkg::ST_WALK:
            begin
                ectl.valid = (idx_reg != '0);
                if (last_vertex)
                begin
                    state_next = pwa_pkg::ST_CLOSE;
                end
            end
            pwa_pkg::ST_CLOSE:
            begin
                ectl.valid = 1'b1;
                state_next = pwa_pkg::ST_DRAIN;
            end
            pwa_pkg::ST_DRAIN:
            begin
                state_next = pwa_pkg::ST_FINISH;
            end
            pwa_pkg::ST_FINISH:
            begin
                state_next = pwa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pwa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (accept && state_next == pwa_pkg::ST_IDLE)
                        || (state_reg == pwa_pkg::ST_FINISH);
            if (accept && kind_in == pwa_pkg::KIND_CLEAR)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (do_write)
            begin
                count_reg <= count_reg + pwa_pkg::CNT_W'(1);
            end
            else if (accept && kind_in == pwa_pkg::KIND_APPEND && !is_dup)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (wind_acc > pwa_pkg::WIND_HI)
            wind_sat = pwa_pkg::WIND_HI;
        else if (wind_acc < pwa_pkg::WIND_LO)
            wind_sat = pwa_pkg::WIND_LO;
        else
            wind_sat = wind_acc;
        if (area_acc > pwa_pkg::AREA_HI)
            area_sat = pwa_pkg::AREA_HI;
        else if (area_acc < pwa_pkg::AREA_LO)
            area_sat = pwa_pkg::AREA_LO;
        else
            area_sat = area_acc;
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            last_reg <= packed_in;
        end
        if (accept)
        begin
            px_reg        <= x_coord;
            py_reg        <= y_coord;
            area_mode_reg <= (kind_in == pwa_pkg::KIND_AREA);
            idx_reg       <= '0;
            inside_reg    <= 1'b0;
            cw_reg        <= 1'b0;
            wind_res_reg  <= '0;
            area_res_reg  <= '0;
        end
        if (state_reg == pwa_pkg::ST_WALK)
        begin
            prev_reg <= rdata;
            idx_reg  <= idx_reg + pwa_pkg::ADDR_W'(1);
            if (idx_reg == '0)
            begin
                first_reg <= rdata;
            end
        end
        if (state_reg == pwa_pkg::ST_FINISH)
        begin
            if (area_mode_reg)
            begin
                area_res_reg <= area_sat[pwa_pkg::AREA_W-1:0];
                cw_reg       <= area_sat < 0;
            end
            else
            begin
                wind_res_reg <= wind_sat[pwa_pkg::WIND_W-1:0];
                inside_reg   <= wind_sat != 0;
            end
        end
    end

    assign busy         = (state_reg != pwa_pkg::ST_IDLE);
    assign done         = done_reg;
    assign inside_res   = inside_reg;
    assign winding      = wind_res_reg;
    assign double_area  = area_res_reg;
    assign clockwise    = cw_reg;
    assign vertex_count = pwa_pkg::VCNT_W'(count_reg);
    assign overflowed   = ovf_reg;

endmodule

>>> design/pwa_vertex_store.sv
`timescale 1ns / 1ps

module pwa_vertex_store (
    input  logic                                clk,
    input  logic                                we,
    input  logic [pwa_pkg::ADDR_W-1:0]          waddr,
    input  logic [pwa_pkg::VERT_W-1:0]          wdata,
    input  logic [pwa_pkg::ADDR_W-1:0]          raddr,
    output logic [pwa_pkg::VERT_W-1:0]          rdata
);

    logic [pwa_pkg::VERT_W-1:0] mem [pwa_pkg::MAX_VERTICES];
    logic [pwa_pkg::VERT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/pwa_edge_unit.sv
`timescale 1ns / 1ps

module pwa_edge_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pwa_pkg::pwa_edge_ctl_t                 ctl,
    input  logic signed [pwa_pkg::COORD_W-1:0]     ax,
    input  logic signed [pwa_pkg::COORD_W-1:0]     ay,
    input  logic signed [pwa_pkg::COORD_W-1:0]     bx,
    input  logic signed [pwa_pkg::COORD_W-1:0]     by,
    input  logic signed [pwa_pkg::COORD_W-1:0]     px,
    input  logic signed [pwa_pkg::COORD_W-1:0]     py,
    output logic signed [pwa_pkg::WACC_W-1:0]      wind_acc,
    output logic signed [pwa_pkg::AACC_W-1:0]      area_acc
);

    logic signed [pwa_pkg::OP_W-1:0]   a1, b1, a2, b2;
    logic signed [pwa_pkg::PROD_W-1:0] prod1_reg, prod2_reg;
    logic                              valid_reg, area_reg, up_reg, down_reg;
    logic signed [pwa_pkg::DIFF_W-1:0] diff;
    logic signed [pwa_pkg::WACC_W-1:0] wind_acc_reg;
    logic signed [pwa_pkg::AACC_W-1:0] area_acc_reg;

    // area: ax*by - ay*bx; point: (bx-ax)*(py-ay) - (px-ax)*(by-ay)
    always_comb
    begin
        if (ctl.area_mode)
        begin
            a1 = pwa_pkg::OP_W'(ax);
            b1 = pwa_pkg::OP_W'(by);
            a2 = pwa_pkg::OP_W'(ay);
            b2 = pwa_pkg::OP_W'(bx);
        end
        else
        begin
            a1 = pwa_pkg::OP_W'(bx) - pwa_pkg::OP_W'(ax);
            b1 = pwa_pkg::OP_W'(py) - pwa_pkg::OP_W'(ay);
            a2 = pwa_pkg::OP_W'(px) - pwa_pkg::OP_W'(ax);
            b2 = pwa_pkg::OP_W'(by) - pwa_pkg::OP_W'(ay);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= a1 * b1;
        prod2_reg <= a2 * b2;
        area_reg  <= ctl.area_mode;
        up_reg    <= (ay <= py) && (by > py);
        down_reg  <= (ay > py) && (by <= py);
    end

    assign diff = pwa_pkg::DIFF_W'(prod1_reg) - pwa_pkg::DIFF_W'(prod2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wind_acc_reg <= '0;
            area_acc_reg <= '0;
        end
        else if (ctl.clear)
        begin
            wind_acc_reg <= '0;
            area_acc_reg <= '0;
        end
        else if (valid_reg)
        begin
            if (area_reg)
            begin
                area_acc_reg <= area_acc_reg + pwa_pkg::AACC_W'(diff);
            end
            else if (up_reg && (diff > 0))
            begin
                wind_acc_reg <= wind_acc_reg + pwa_pkg::WACC_W'(1);
            end
            else if (down_reg && !(diff > 0))
            begin
                wind_acc_reg <= wind_acc_reg - pwa_pkg::WACC_W'(1);
            end
        end
    end

    assign wind_acc = wind_acc_reg;
    assign area_acc = area_acc_reg;

endmodule

>>> design/pwa_checker.sv
`timescale 1ns / 1ps

module pwa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic                                inside_res,
    input logic signed [pwa_pkg::WIND_W-1:0]   winding,
    input logic signed [pwa_pkg::AREA_W-1:0]   double_area,
    input logic                                clockwise
);

    // a transfer either finishes next cycle or starts a walk
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("transfer neither answered nor started");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_walk_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query ended without a result");

    a_inside_wind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && inside_res) |-> (winding != 0))
        else $error("inside with zero winding");

    a_cw_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clockwise) |-> double_area[pwa_pkg::AREA_W-1])
        else $error("clockwise with nonnegative area");

endmodule

bind polygon_winding_and_area_unit pwa_checker u_pwa_checker (.*);
